/* sv/kmc_pkg.sv */
// Shared types and constants for the k-means clustering core.
// Operation and result codes, register indexes, controller states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package kmc_pkg;

    localparam int DEF_MAX_SAMPLES  = 256;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_DIMS     = 16;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CLUS_W     = 3;
    localparam int MCNT_W     = 9;
    localparam int ITER_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CFG_NS_W  = 9;
    localparam int CFG_NC_W  = 4;
    localparam int CFG_ND_W  = 5;
    localparam int CFG_TOL_W = 16;

    localparam logic [CFG_NS_W-1:0]  RST_SAMPLES   = 9'd256;
    localparam logic [CFG_NC_W-1:0]  RST_CLUSTERS  = 4'd2;
    localparam logic [CFG_ND_W-1:0]  RST_DIMS      = 5'd3;
    localparam logic [CFG_TOL_W-1:0] RST_TOLERANCE = 16'd0;
    localparam logic [ITER_W-1:0]    RST_ITER_LIM  = 10'd100;

    typedef enum logic [OP_W-1:0] {
        OP_LD_SMP   = 2'd0,
        OP_LD_MEAN  = 2'd1,
        OP_RD_MEAN  = 2'd2,
        OP_RD_LABEL = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_MEAN  = 2'd1,
        KIND_LABEL = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT  = 3'd0,
        CFG_CLUSTER_COUNT = 3'd1,
        CFG_DIMENSIONS    = 3'd2,
        CFG_TOLERANCE     = 3'd3,
        CFG_ITER_LIMIT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RUN, S_PASS, S_CLR, S_SI, S_KI, S_DRD, S_DSQ, S_DACC,
        S_DCMP, S_LAB, S_SRD, S_SWR, S_SNX, S_UI, S_URD, S_ULAT, S_UWAIT,
        S_PEND, S_DONE
    } t_state;

    typedef struct packed {
        logic load_smp;
        logic load_mean;
        logic rd_mean;
        logic rd_label;
        logic out_read;
        logic out_done;
        logic run_init;
        logic pass_init;
        logic clr_step;
        logic smp_init;
        logic dist_init;
        logic dist_rd;
        logic dist_sq;
        logic dist_acc;
        logic dist_cmp;
        logic lab_wr;
        logic sum_rd;
        logic sum_wr;
        logic smp_next;
        logic upd_init;
        logic upd_rd;
        logic upd_latch;
        logic upd_wr;
        logic pass_end;
    } t_cmd;

    typedef struct packed {
        logic j_last;
        logic k_last;
        logic i_last;
        logic m_last;
        logic moved;
        logic iter_last;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

/* sv/kmc_if.sv */
// Handshake channel interfaces of the k-means core: item input, result
// output and configuration write. Depends on kmc_pkg.
`timescale 1ns / 1ps

interface kmc_in_if;
    import kmc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    modport source(output valid, op, index, value, last, input ready);
    modport sink(input valid, op, index, value, last, output ready);
endinterface

interface kmc_out_if;
    import kmc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] mean_value;
    logic [CLUS_W-1:0]       cluster;
    logic [MCNT_W-1:0]       member_count;
    logic [ITER_W-1:0]       iterations;
    logic                    converged;
    modport source(output valid, kind, mean_value, cluster, member_count, iterations,
                   converged, input ready);
    modport sink(input valid, kind, mean_value, cluster, member_count, iterations,
                 converged, output ready);
endinterface

interface kmc_cfg_if;
    import kmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* sv/kmeans_clustering_core.sv */
// Top level of the k-means clustering core: channels, controller, datapath.
// Depends on kmc_pkg, kmc_if, kmc_ctrl and kmc_dp.
//
// Usage: configure the five registers over i_cfg while idle (always ready).
// Items on i_in: op 0 writes a sample coordinate, op 1 an initial mean
// coordinate, op 2 reads a mean coordinate, op 3 reads a sample label.
// Loads give no result, and i_in stays ready after a load that starts no run.
// Reads give one result on o_out once the result register is free; i_in is held
// off until it is loaded. A sample load with last set starts clustering: i_in
// stays low until the done transaction is queued. Each pass walks the
// coordinates one by one over memories with one read port each and runs
// the bit-serial divider (SUM_W = 16 + log2 MAX_SAMPLES) once per mean
// coordinate of every non-empty cluster.
// The result register parts the channels: loads are accepted while a result
// waits on a stalled o_out; reads and the done result wait for it to drain.
// Reset restores register defaults and empties the result register; labels
// read as zero until a run has covered them.
`timescale 1ns / 1ps

module kmeans_clustering_core #(
    parameter int MAX_SAMPLES  = kmc_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = kmc_pkg::DEF_MAX_DIMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmc_cfg_if.sink     i_cfg,
    kmc_in_if.sink      i_in,
    kmc_out_if.source   o_out
);
    import kmc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_acc;

    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    kmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kmc_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_in_index     (i_in.index),
        .i_in_value     (i_in.value),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_kind         (o_out.kind),
        .o_mean_value   (o_out.mean_value),
        .o_cluster      (o_out.cluster),
        .o_member_count (o_out.member_count),
        .o_iterations   (o_out.iterations),
        .o_converged    (o_out.converged)
    );

    a_read_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.op == OP_RD_MEAN || i_in.op == OP_RD_LABEL)) |=> !i_in.ready)
        else $error("input accepted while a read is outstanding");

    a_run_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.op == OP_LD_SMP && i_in.last) |=> !i_in.ready)
        else $error("input accepted after clustering start");

    a_div_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd_wr |-> !w_sts.div_busy)
        else $error("mean written while divider busy");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_read || w_cmd.out_done) |-> !o_out.valid)
        else $error("result register overwritten");

endmodule

/* sv/kmc_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Used by the datapath for the mean update. Depends on nothing.
`timescale 1ns / 1ps

module kmc_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic             q_bit;
    logic [DVS_W:0]   n_rem;

    always_comb begin
        rem_sh = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        n_rem  = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

/* sv/kmc_ctrl.sv */
// Controller state machine of the k-means core: item handshake and the
// sequencing of each Lloyd pass. Depends on kmc_pkg.
`timescale 1ns / 1ps

module kmc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [kmc_pkg::OP_W-1:0]    i_in_op,
    input  logic                        i_in_last,
    output logic                        o_in_ready,
    input  kmc_pkg::t_sts               i_sts,
    output kmc_pkg::t_cmd               o_cmd
);
    import kmc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_in_op))
                        OP_LD_SMP:   n_state = i_in_last ? S_RUN : S_IDLE;
                        OP_RD_MEAN:  n_state = S_RD;
                        OP_RD_LABEL: n_state = S_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:    if (i_sts.out_free) n_state = S_IDLE;
            S_RUN:   n_state = S_PASS;
            S_PASS:  n_state = S_CLR;
            S_CLR:   if (i_sts.m_last) n_state = S_SI;
            S_SI:    n_state = S_KI;
            S_KI:    n_state = S_DRD;
            S_DRD:   n_state = S_DSQ;
            S_DSQ:   n_state = S_DACC;
            S_DACC:  n_state = i_sts.j_last ? S_DCMP : S_DRD;
            S_DCMP:  n_state = i_sts.k_last ? S_LAB : S_DRD;
            S_LAB:   n_state = S_SRD;
            S_SRD:   n_state = S_SWR;
            S_SWR:   n_state = i_sts.j_last ? S_SNX : S_SRD;
            S_SNX:   n_state = i_sts.i_last ? S_UI : S_KI;
            S_UI:    n_state = S_URD;
            S_URD:   n_state = S_ULAT;
            S_ULAT:  n_state = S_UWAIT;
            S_UWAIT: if (!i_sts.div_busy) n_state = i_sts.m_last ? S_PEND : S_URD;
            S_PEND:  n_state = (!i_sts.moved || i_sts.iter_last) ? S_DONE : S_PASS;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_op'(i_in_op))
                        OP_LD_SMP:   o_cmd.load_smp  = 1'b1;
                        OP_LD_MEAN:  o_cmd.load_mean = 1'b1;
                        OP_RD_MEAN:  o_cmd.rd_mean   = 1'b1;
                        OP_RD_LABEL: o_cmd.rd_label  = 1'b1;
                        default:     o_cmd.load_smp  = 1'b0;
                    endcase
                end
            end
            S_RD:    o_cmd.out_read  = i_sts.out_free;
            S_RUN:   o_cmd.run_init  = 1'b1;
            S_PASS:  o_cmd.pass_init = 1'b1;
            S_CLR:   o_cmd.clr_step  = 1'b1;
            S_SI:    o_cmd.smp_init  = 1'b1;
            S_KI:    o_cmd.dist_init = 1'b1;
            S_DRD:   o_cmd.dist_rd   = 1'b1;
            S_DSQ:   o_cmd.dist_sq   = 1'b1;
            S_DACC:  o_cmd.dist_acc  = 1'b1;
            S_DCMP:  o_cmd.dist_cmp  = 1'b1;
            S_LAB:   o_cmd.lab_wr    = 1'b1;
            S_SRD:   o_cmd.sum_rd    = 1'b1;
            S_SWR:   o_cmd.sum_wr    = 1'b1;
            S_SNX:   o_cmd.smp_next  = 1'b1;
            S_UI:    o_cmd.upd_init  = 1'b1;
            S_URD:   o_cmd.upd_rd    = 1'b1;
            S_ULAT:  o_cmd.upd_latch = 1'b1;
            S_UWAIT: o_cmd.upd_wr    = !i_sts.div_busy;
            S_PEND:  o_cmd.pass_end  = 1'b1;
            S_DONE:  o_cmd.out_done  = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/kmc_dp.sv */
// Datapath of the k-means core: configuration registers, sample, mean, sum
// and label memories, distance and sum arithmetic, output register.
// Depends on kmc_pkg and kmc_div.
`timescale 1ns / 1ps

module kmc_dp #(
    parameter int MAX_SAMPLES  = kmc_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = kmc_pkg::DEF_MAX_DIMS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kmc_pkg::t_cmd                     i_cmd,
    output kmc_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [kmc_pkg::IDX_W-1:0]         i_in_index,
    input  logic signed [kmc_pkg::VAL_W-1:0]  i_in_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [kmc_pkg::KIND_W-1:0]        o_kind,
    output logic signed [kmc_pkg::VAL_W-1:0]  o_mean_value,
    output logic [kmc_pkg::CLUS_W-1:0]        o_cluster,
    output logic [kmc_pkg::MCNT_W-1:0]        o_member_count,
    output logic [kmc_pkg::ITER_W-1:0]        o_iterations,
    output logic                              o_converged
);
    import kmc_pkg::*;

    localparam int SD    = MAX_SAMPLES * MAX_DIMS;
    localparam int MD    = MAX_CLUSTERS * MAX_DIMS;
    localparam int SA_W  = $clog2(SD);
    localparam int MA_W  = $clog2(MD);
    localparam int I_W   = $clog2(MAX_SAMPLES);
    localparam int K_W   = $clog2(MAX_CLUSTERS);
    localparam int J_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int NC_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int ND_W  = $clog2(MAX_DIMS + 1);
    localparam int MC_W  = $clog2(MD + 1);
    localparam int SUM_W = VAL_W + $clog2(MAX_SAMPLES);
    localparam int SQ_W  = 2 * VAL_W + 1;
    localparam int D_W   = SQ_W + ND_W;

    // configuration
    logic [CFG_NS_W-1:0]  r_cfg_ns;
    logic [CFG_NC_W-1:0]  r_cfg_nc;
    logic [CFG_ND_W-1:0]  r_cfg_nd;
    logic [CFG_TOL_W-1:0] r_cfg_tol;
    logic [ITER_W-1:0]    r_cfg_lim;

    logic [NS_W-1:0]   ns;
    logic [NC_W-1:0]   nc;
    logic [ND_W-1:0]   nd;
    logic [MC_W-1:0]   ncnd;
    logic [ITER_W-1:0] lim;

    // sequencing counters
    logic [I_W-1:0]      r_i;
    logic [K_W-1:0]      r_k;
    logic [J_W-1:0]      r_j;
    logic [MA_W-1:0]     r_m;
    logic [SA_W-1:0]     r_sbase;
    logic [MA_W-1:0]     r_mbase;
    logic [MA_W-1:0]     r_bbase;
    logic [K_W-1:0]      r_bestk;
    logic [D_W-1:0]      r_best;
    logic [D_W-1:0]      r_acc;
    logic [SQ_W-1:0]     r_sq;
    logic [ITER_W-1:0]   r_iter;
    logic                r_moved;
    logic [NS_W-1:0]     r_fill;
    logic [NS_W-1:0]     r_sizes [MAX_CLUSTERS];
    logic signed [VAL_W-1:0] r_prev;
    logic                r_neg;

    // read capture
    logic            r_rd_label;
    logic            r_rd_ok;
    logic            r_rd_lab_vld;
    logic [K_W-1:0]  r_rd_c;
    logic [K_W-1:0]  rd_c;
    logic [K_W-1:0]  c_out;

    // memories
    logic signed [VAL_W-1:0] r_smp_mem  [SD];
    logic signed [VAL_W-1:0] r_mean_mem [MD];
    logic signed [SUM_W-1:0] r_sum_mem  [MD];
    logic [K_W-1:0]          r_lab_mem  [MAX_SAMPLES];
    logic signed [VAL_W-1:0] r_smp_rdata;
    logic signed [VAL_W-1:0] r_mean_rdata;
    logic signed [SUM_W-1:0] r_sum_rdata;
    logic [K_W-1:0]          r_lab_rdata;

    logic                    smp_we;
    logic                    smp_re;
    logic [SA_W-1:0]         smp_raddr;
    logic                    mean_we;
    logic                    mean_re;
    logic [MA_W-1:0]         mean_waddr;
    logic [MA_W-1:0]         mean_raddr;
    logic signed [VAL_W-1:0] mean_wdata;
    logic                    sum_we;
    logic                    sum_re;
    logic [MA_W-1:0]         sum_waddr;
    logic [MA_W-1:0]         sum_raddr;
    logic signed [SUM_W-1:0] sum_wdata;

    logic [K_W-1:0]          size_idx;
    logic [NS_W-1:0]         size_sel;
    logic                    size_zero;
    logic signed [VAL_W:0]   d_diff;
    logic signed [2*VAL_W+1:0] d_prod;
    logic [SUM_W-1:0]        sum_mag;
    logic                    div_busy;
    logic [SUM_W-1:0]        div_quo;
    logic signed [VAL_W-1:0] new_mean;
    logic signed [VAL_W:0]   mv_diff;
    logic [VAL_W:0]          mv_mag;

    logic                    r_out_valid;
    logic [KIND_W-1:0]       r_kind;
    logic signed [VAL_W-1:0] r_mean_value;
    logic [CLUS_W-1:0]       r_cluster;
    logic [MCNT_W-1:0]       r_member_count;
    logic [ITER_W-1:0]       r_iterations;
    logic                    r_converged;

    assign ns = (r_cfg_ns == '0) ? NS_W'(1) :
                ((int'(r_cfg_ns) > MAX_SAMPLES) ? NS_W'(MAX_SAMPLES) : NS_W'(r_cfg_ns));
    assign nc = (r_cfg_nc == '0) ? NC_W'(1) :
                ((int'(r_cfg_nc) > MAX_CLUSTERS) ? NC_W'(MAX_CLUSTERS) : NC_W'(r_cfg_nc));
    assign nd = (r_cfg_nd == '0) ? ND_W'(1) :
                ((int'(r_cfg_nd) > MAX_DIMS) ? ND_W'(MAX_DIMS) : ND_W'(r_cfg_nd));
    assign lim  = (r_cfg_lim == '0) ? ITER_W'(1) : r_cfg_lim;
    assign ncnd = MC_W'(nc) * MC_W'(nd);

    assign o_sts.j_last    = (ND_W'(r_j) + ND_W'(1)) == nd;
    assign o_sts.k_last    = (NC_W'(r_k) + NC_W'(1)) == nc;
    assign o_sts.i_last    = (NS_W'(r_i) + NS_W'(1)) == ns;
    assign o_sts.m_last    = (MC_W'(r_m) + MC_W'(1)) == ncnd;
    assign o_sts.moved     = r_moved;
    assign o_sts.iter_last = (r_iter + ITER_W'(1)) == lim;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_free  = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ns  <= RST_SAMPLES;
            r_cfg_nc  <= RST_CLUSTERS;
            r_cfg_nd  <= RST_DIMS;
            r_cfg_tol <= RST_TOLERANCE;
            r_cfg_lim <= RST_ITER_LIM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_COUNT:  r_cfg_ns  <= i_cfg_data[CFG_NS_W-1:0];
                CFG_CLUSTER_COUNT: r_cfg_nc  <= i_cfg_data[CFG_NC_W-1:0];
                CFG_DIMENSIONS:    r_cfg_nd  <= i_cfg_data[CFG_ND_W-1:0];
                CFG_TOLERANCE:     r_cfg_tol <= i_cfg_data[CFG_TOL_W-1:0];
                CFG_ITER_LIMIT:    r_cfg_lim <= i_cfg_data[ITER_W-1:0];
                default:           r_cfg_lim <= r_cfg_lim;
            endcase
        end
    end

    // cluster of a mean element: highest cluster whose base lies at or below the index
    always_comb begin
        rd_c = '0;
        for (int c = 1; c < MAX_CLUSTERS; c++) begin
            if (c * int'(nd) <= int'(i_in_index)) begin
                rd_c = K_W'(c);
            end
        end
    end

    assign c_out = r_rd_label ? (r_rd_lab_vld ? r_lab_rdata : '0) : r_rd_c;

    always_comb begin
        if (i_cmd.lab_wr) begin
            size_idx = r_bestk;
        end else if (i_cmd.out_read) begin
            size_idx = c_out;
        end else begin
            size_idx = r_k;
        end
    end
    assign size_sel  = r_sizes[size_idx];
    assign size_zero = (size_sel == '0);

    // memory port selection
    assign smp_we    = i_cmd.load_smp && (int'(i_in_index) < SD);
    assign smp_re    = i_cmd.dist_rd || i_cmd.sum_rd;
    assign smp_raddr = r_sbase + SA_W'(r_j);

    assign mean_we    = (i_cmd.load_mean && (int'(i_in_index) < MD)) || i_cmd.upd_wr;
    assign mean_waddr = i_cmd.upd_wr ? r_m : MA_W'(i_in_index);
    assign mean_wdata = i_cmd.upd_wr ? new_mean : i_in_value;
    assign mean_re    = i_cmd.rd_mean || i_cmd.dist_rd || i_cmd.upd_rd;
    always_comb begin
        if (i_cmd.rd_mean) begin
            mean_raddr = MA_W'(i_in_index);
        end else if (i_cmd.upd_rd) begin
            mean_raddr = r_m;
        end else begin
            mean_raddr = r_mbase + MA_W'(r_j);
        end
    end

    assign sum_we    = i_cmd.clr_step || i_cmd.sum_wr;
    assign sum_waddr = i_cmd.clr_step ? r_m : (r_bbase + MA_W'(r_j));
    assign sum_wdata = i_cmd.clr_step ? '0 :
                       (r_sum_rdata + {{(SUM_W-VAL_W){r_smp_rdata[VAL_W-1]}}, r_smp_rdata});
    assign sum_re    = i_cmd.sum_rd || i_cmd.upd_rd;
    assign sum_raddr = i_cmd.upd_rd ? r_m : (r_bbase + MA_W'(r_j));

    always_ff @(posedge i_clk) begin
        if (smp_we) r_smp_mem[SA_W'(i_in_index)] <= i_in_value;
        if (smp_re) r_smp_rdata <= r_smp_mem[smp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mean_we) r_mean_mem[mean_waddr] <= mean_wdata;
        if (mean_re) r_mean_rdata <= r_mean_mem[mean_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_waddr] <= sum_wdata;
        if (sum_re) r_sum_rdata <= r_sum_mem[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lab_wr)   r_lab_mem[r_i] <= r_bestk;
        if (i_cmd.rd_label) r_lab_rdata <= r_lab_mem[I_W'(i_in_index)];
    end

    // distance and mean arithmetic
    assign d_diff = {r_mean_rdata[VAL_W-1], r_mean_rdata}
                  - {r_smp_rdata[VAL_W-1], r_smp_rdata};
    assign d_prod = d_diff * d_diff;

    assign sum_mag = r_sum_rdata[SUM_W-1] ? SUM_W'(-r_sum_rdata) : SUM_W'(r_sum_rdata);

    kmc_div #(
        .DVD_W(SUM_W),
        .DVS_W(NS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.upd_latch && !size_zero),
        .i_dividend (sum_mag),
        .i_divisor  (size_sel),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign new_mean = size_zero ? r_prev
                    : VAL_W'(r_neg ? (~div_quo + SUM_W'(1)) : div_quo);
    assign mv_diff  = {r_prev[VAL_W-1], r_prev} - {new_mean[VAL_W-1], new_mean};
    assign mv_mag   = mv_diff[VAL_W] ? (VAL_W+1)'(-mv_diff) : (VAL_W+1)'(mv_diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_sq) r_sq <= d_prod[SQ_W-1:0];
        if (i_cmd.upd_latch) begin
            r_prev <= r_mean_rdata;
            r_neg  <= r_sum_rdata[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_m      <= '0;
            r_sbase  <= '0;
            r_mbase  <= '0;
            r_bbase  <= '0;
            r_bestk  <= '0;
            r_best   <= '0;
            r_acc    <= '0;
            r_iter   <= '0;
            r_moved  <= 1'b0;
            r_fill   <= '0;
            for (int c = 0; c < MAX_CLUSTERS; c++) r_sizes[c] <= '0;
        end else begin
            if (i_cmd.run_init) begin
                r_iter <= '0;
                if (ns > r_fill) r_fill <= ns;
            end
            if (i_cmd.pass_init) begin
                r_moved <= 1'b0;
                r_m     <= '0;
                for (int c = 0; c < MAX_CLUSTERS; c++) r_sizes[c] <= '0;
            end
            if (i_cmd.clr_step) r_m <= r_m + MA_W'(1);
            if (i_cmd.smp_init) begin
                r_i     <= '0;
                r_sbase <= '0;
            end
            if (i_cmd.dist_init) begin
                r_k     <= '0;
                r_mbase <= '0;
                r_j     <= '0;
                r_acc   <= '0;
            end
            if (i_cmd.dist_acc) begin
                r_acc <= r_acc + D_W'(r_sq);
                r_j   <= r_j + J_W'(1);
            end
            if (i_cmd.dist_cmp) begin
                if (r_k == '0 || r_acc < r_best) begin
                    r_best  <= r_acc;
                    r_bestk <= r_k;
                    r_bbase <= r_mbase;
                end
                r_k     <= r_k + K_W'(1);
                r_mbase <= r_mbase + MA_W'(nd);
                r_j     <= '0;
                r_acc   <= '0;
            end
            if (i_cmd.lab_wr) begin
                r_sizes[r_bestk] <= size_sel + NS_W'(1);
                r_j              <= '0;
            end
            if (i_cmd.sum_wr) r_j <= r_j + J_W'(1);
            if (i_cmd.smp_next) begin
                r_i     <= r_i + I_W'(1);
                r_sbase <= r_sbase + SA_W'(nd);
            end
            if (i_cmd.upd_init) begin
                r_m <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            if (i_cmd.upd_wr) begin
                r_m <= r_m + MA_W'(1);
                if (o_sts.j_last) begin
                    r_j <= '0;
                    r_k <= r_k + K_W'(1);
                end else begin
                    r_j <= r_j + J_W'(1);
                end
                if (mv_mag > {1'b0, r_cfg_tol}) r_moved <= 1'b1;
            end
            if (i_cmd.pass_end) r_iter <= r_iter + ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mean) begin
            r_rd_label <= 1'b0;
            r_rd_ok    <= int'(i_in_index) < int'(ncnd);
            r_rd_c     <= rd_c;
        end
        if (i_cmd.rd_label) begin
            r_rd_label   <= 1'b1;
            r_rd_ok      <= int'(i_in_index) < int'(ns);
            r_rd_lab_vld <= int'(i_in_index) < int'(r_fill);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_read || i_cmd.out_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_read) begin
            r_kind         <= r_rd_label ? KIND_LABEL : KIND_MEAN;
            r_mean_value   <= (!r_rd_label && r_rd_ok) ? r_mean_rdata : '0;
            r_cluster      <= r_rd_ok ? CLUS_W'(c_out) : '0;
            r_member_count <= r_rd_ok ? MCNT_W'(size_sel) : '0;
            r_iterations   <= '0;
            r_converged    <= 1'b0;
        end else if (i_cmd.out_done) begin
            r_kind         <= KIND_DONE;
            r_mean_value   <= '0;
            r_cluster      <= '0;
            r_member_count <= '0;
            r_iterations   <= r_iter;
            r_converged    <= !r_moved;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_mean_value   = r_mean_value;
    assign o_cluster      = r_cluster;
    assign o_member_count = r_member_count;
    assign o_iterations   = r_iterations;
    assign o_converged    = r_converged;

endmodule

/* sim/kmeans_clustering_core_test.sv */
// Testbench for kmeans_clustering_core: loads data sets, runs clustering and reads back
// means and labels, checking every result against a behavioural predictor.
// Depends on kmc_pkg, kmc_if and the core RTL.
`timescale 1ns / 1ps

module kmeans_clustering_core_test;
    import kmc_pkg::*;

    localparam int SMP_DEPTH   = DEF_MAX_SAMPLES * DEF_MAX_DIMS;
    localparam int MEAN_DEPTH  = DEF_MAX_CLUSTERS * DEF_MAX_DIMS;
    localparam int CYCLE_LIMIT = 200000000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        t_kind                   kind;
        logic signed [VAL_W-1:0] mean_value;
        logic [CLUS_W-1:0]       cluster;
        logic [MCNT_W-1:0]       member_count;
        logic [ITER_W-1:0]       iterations;
        logic                    converged;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    kmc_in_if  in_ch();
    kmc_out_if out_ch();
    kmc_cfg_if cfg_ch();

    kmeans_clustering_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // predictor state
    int  reg_ns, reg_nc, reg_nd, reg_tol, reg_lim;
    int  smp_mem [SMP_DEPTH];
    int  mean_mem [MEAN_DEPTH];
    int  prev_mean [MEAN_DEPTH];
    longint coord_sum [MEAN_DEPTH];
    int  label_mem [DEF_MAX_SAMPLES];
    int  cluster_size [DEF_MAX_CLUSTERS];
    int  iter_count;
    bit  has_settled;
    bit  mean_loaded [MEAN_DEPTH];

    t_result expected_results[$];
    int  error_count;
    int  cycle_count;
    int  items_sent;
    int  src_idle_pct;
    int  snk_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic queue_result(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction kind", out_ch.kind, -1);
            end else begin
                e = expected_results.pop_front();
                if (out_ch.kind !== e.kind)
                    report_mismatch("kind", out_ch.kind, e.kind);
                if (out_ch.mean_value !== e.mean_value)
                    report_mismatch("mean_value", out_ch.mean_value, e.mean_value);
                if (out_ch.cluster !== e.cluster)
                    report_mismatch("cluster", out_ch.cluster, e.cluster);
                if (out_ch.member_count !== e.member_count)
                    report_mismatch("member_count", out_ch.member_count, e.member_count);
                if (out_ch.iterations !== e.iterations)
                    report_mismatch("iterations", out_ch.iterations, e.iterations);
                if (out_ch.converged !== e.converged)
                    report_mismatch("converged", out_ch.converged, e.converged);
            end
        end
    end

    function automatic int clamp_reg(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic bit lloyd_pass(input int ns, input int nc, input int nd);
        bit     moved;
        longint best, sq_dist, diff;
        int     best_k, mag;
        moved = 1'b0;
        for (int k = 0; k < DEF_MAX_CLUSTERS; k++) cluster_size[k] = 0;
        for (int k = 0; k < MEAN_DEPTH; k++) coord_sum[k] = 0;
        for (int i = 0; i < ns; i++) begin
            best = 0;
            best_k = 0;
            for (int k = 0; k < nc; k++) begin
                sq_dist = 0;
                for (int j = 0; j < nd; j++) begin
                    diff = longint'(mean_mem[k*nd+j]) - longint'(smp_mem[i*nd+j]);
                    sq_dist += diff * diff;
                end
                if (k == 0 || sq_dist < best) begin
                    best = sq_dist;
                    best_k = k;
                end
            end
            label_mem[i] = best_k;
            cluster_size[best_k]++;
            for (int j = 0; j < nd; j++)
                coord_sum[best_k*nd+j] += smp_mem[i*nd+j];
        end
        for (int k = 0; k < nc*nd; k++) prev_mean[k] = mean_mem[k];
        for (int k = 0; k < nc; k++) begin
            if (cluster_size[k] != 0)
                for (int j = 0; j < nd; j++)
                    mean_mem[k*nd+j] = int'(coord_sum[k*nd+j] / longint'(cluster_size[k]));
        end
        for (int k = 0; k < nc*nd; k++) begin
            mag = prev_mean[k] - mean_mem[k];
            if (mag < 0) mag = -mag;
            if (mag > reg_tol) moved = 1'b1;
        end
        return moved;
    endfunction

    task automatic run_lloyd();
        int ns, nc, nd, lim;
        ns = clamp_reg(reg_ns, DEF_MAX_SAMPLES);
        nc = clamp_reg(reg_nc, DEF_MAX_CLUSTERS);
        nd = clamp_reg(reg_nd, DEF_MAX_DIMS);
        lim = clamp_reg(reg_lim, 1023);
        iter_count = 0;
        has_settled = 1'b0;
        while (iter_count < lim) begin
            iter_count++;
            if (!lloyd_pass(ns, nc, nd)) begin
                has_settled = 1'b1;
                break;
            end
        end
    endtask

    task automatic predict_kmeans(input t_op op, input int idx, input int val, input bit lst);
        t_result r;
        int nc, nd, ns, c;
        nc = clamp_reg(reg_nc, DEF_MAX_CLUSTERS);
        nd = clamp_reg(reg_nd, DEF_MAX_DIMS);
        ns = clamp_reg(reg_ns, DEF_MAX_SAMPLES);
        r.kind = KIND_DONE;
        r.mean_value = '0;
        r.cluster = '0;
        r.member_count = '0;
        r.iterations = '0;
        r.converged = 1'b0;
        case (op)
            OP_LD_SMP: begin
                if (idx < SMP_DEPTH) smp_mem[idx] = val;
                if (lst) begin
                    run_lloyd();
                    r.iterations = iter_count[ITER_W-1:0];
                    r.converged = has_settled;
                    queue_result(r);
                end
            end
            OP_LD_MEAN: begin
                if (idx < MEAN_DEPTH) begin
                    mean_mem[idx] = val;
                    mean_loaded[idx] = 1'b1;
                end
            end
            OP_RD_MEAN: begin
                r.kind = KIND_MEAN;
                if (idx < nc*nd) begin
                    c = idx / nd;
                    r.mean_value = mean_mem[idx][VAL_W-1:0];
                    r.cluster = c[CLUS_W-1:0];
                    r.member_count = cluster_size[c][MCNT_W-1:0];
                end
                queue_result(r);
            end
            default: begin
                r.kind = KIND_LABEL;
                if (idx < ns) begin
                    c = label_mem[idx] % DEF_MAX_CLUSTERS;
                    r.cluster = c[CLUS_W-1:0];
                    r.member_count = cluster_size[c][MCNT_W-1:0];
                end
                queue_result(r);
            end
        endcase
    endtask

    task automatic send_item(input t_op op, input int idx, input int val, input bit lst);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.index <= idx[IDX_W-1:0];
        in_ch.value <= val[VAL_W-1:0];
        in_ch.last  <= lst;
        predict_kmeans(op, idx, $signed(val[VAL_W-1:0]), lst);
        items_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // pause the sender until every result has come back, then let loads settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_config(input int ns, input int nc, input int nd, input int tol,
                              input int lim);
        t_cfg_idx r;
        int data;
        for (int i = 0; i < 5; i++) begin
            r = t_cfg_idx'(i);
            case (r)
                CFG_SAMPLE_COUNT:  begin data = ns;  reg_ns = ns & 'h1FF; end
                CFG_CLUSTER_COUNT: begin data = nc;  reg_nc = nc & 'hF; end
                CFG_DIMENSIONS:    begin data = nd;  reg_nd = nd & 'h1F; end
                CFG_TOLERANCE:     begin data = tol; reg_tol = tol & 'hFFFF; end
                default:           begin data = lim; reg_lim = lim & 'h3FF; end
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= r;
            cfg_ch.data  <= data[CFG_DATA_W-1:0];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // full data set: every mean and sample element, last on the final sample
    task automatic load_data_set(input bit noisy);
        int nc, nd, ns, idx;
        nc = clamp_reg(reg_nc, DEF_MAX_CLUSTERS);
        nd = clamp_reg(reg_nd, DEF_MAX_DIMS);
        ns = clamp_reg(reg_ns, DEF_MAX_SAMPLES);
        for (int k = 0; k < nc*nd; k++)
            send_item(OP_LD_MEAN, k, $urandom_range(0, 65535), 1'b0);
        for (int i = 0; i < ns*nd; i++) begin
            if (noisy && $urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: begin
                        idx = $urandom_range(0, 4095);
                        if (idx < MEAN_DEPTH && !mean_loaded[idx]) idx = 4095;
                        send_item(OP_RD_MEAN, idx, $urandom_range(0, 65535),
                                  1'($urandom_range(1)));
                    end
                    1: send_item(OP_RD_LABEL, $urandom_range(0, 4095), 0,
                                 1'($urandom_range(1)));
                    2: send_item(OP_LD_MEAN, $urandom_range(MEAN_DEPTH, 4095),
                                 $urandom_range(0, 65535), 1'($urandom_range(1)));
                    default: send_item(OP_LD_SMP, $urandom_range(0, 4095),
                                       $urandom_range(0, 65535), 1'b0);
                endcase
            end
            send_item(OP_LD_SMP, i, $urandom_range(0, 65535), i == ns*nd-1);
        end
    endtask

    task automatic read_back(input int count);
        int nc, nd, ns, idx;
        nc = clamp_reg(reg_nc, DEF_MAX_CLUSTERS);
        nd = clamp_reg(reg_nd, DEF_MAX_DIMS);
        ns = clamp_reg(reg_ns, DEF_MAX_SAMPLES);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1)) begin
                idx = ($urandom_range(7) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, nc*nd-1);
                if (idx < MEAN_DEPTH && !mean_loaded[idx]) idx = 4095;
                send_item(OP_RD_MEAN, idx, 0, 1'b0);
            end else begin
                idx = ($urandom_range(7) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, ns-1);
                send_item(OP_RD_LABEL, idx, 0, 1'b0);
            end
        end
    endtask

    task automatic test_directed();
        send_item(OP_RD_LABEL, 0, 0, 1'b0);
        send_item(OP_RD_LABEL, 4095, 0, 1'b1);
        send_item(OP_RD_MEAN, 4095, 0, 1'b1);
        send_item(OP_LD_MEAN, 200, 16'h7FFF, 1'b1);
        wait_drained();
        // zero registers behave as one
        set_config(0, 0, 0, 0, 0);
        send_item(OP_LD_MEAN, 0, 16'h8000, 1'b0);
        send_item(OP_LD_SMP, 0, 16'h7FFF, 1'b1);
        send_item(OP_RD_MEAN, 0, 0, 1'b0);
        send_item(OP_RD_MEAN, 1, 0, 1'b0);
        send_item(OP_RD_LABEL, 0, 0, 1'b0);
        send_item(OP_RD_LABEL, 1, 0, 1'b0);
        wait_drained();
        // tie to the lower index, empty cluster keeps its mean
        set_config(3, 3, 1, 0, 1023);
        send_item(OP_LD_MEAN, 0, -256, 1'b0);
        send_item(OP_LD_MEAN, 1, 256, 1'b0);
        send_item(OP_LD_MEAN, 2, 256, 1'b0);
        send_item(OP_LD_SMP, 0, 0, 1'b0);
        send_item(OP_LD_SMP, 1, -32768, 1'b0);
        send_item(OP_LD_SMP, 2, 32767, 1'b1);
        send_item(OP_RD_MEAN, 2, 0, 1'b0);
        send_item(OP_RD_LABEL, 0, 0, 1'b0);
        send_item(OP_RD_LABEL, 2, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_sets(input int item_target);
        int stop_at, ns, nc, nd, tol, lim;
        stop_at = items_sent + item_target;
        while (items_sent < stop_at) begin
            if ($urandom_range(1)) begin
                ns = $urandom_range(1, 12);
                nc = $urandom_range(1, 4);
                nd = $urandom_range(1, 3);
                case ($urandom_range(3))
                    0: tol = 0;
                    1: tol = $urandom_range(1, 16);
                    2: tol = $urandom_range(0, 65535);
                    default: tol = 65535;
                endcase
                case ($urandom_range(5))
                    0: lim = 1023;
                    1: lim = 0;
                    default: lim = $urandom_range(1, 40);
                endcase
                set_config(ns, nc, nd, tol, lim);
            end
            load_data_set(1'b1);
            read_back($urandom_range(4, 16));
            wait_drained();
        end
    endtask

    task automatic test_largest();
        // oversized registers saturate to the maxima; one pass only
        set_config(511, 15, 1, 65535, 1);
        load_data_set(1'b0);
        send_item(OP_RD_MEAN, DEF_MAX_CLUSTERS-1, 0, 1'b0);
        send_item(OP_RD_LABEL, DEF_MAX_SAMPLES-1, 0, 1'b0);
        send_item(OP_RD_LABEL, DEF_MAX_SAMPLES, 0, 1'b0);
        wait_drained();
        set_config(2, 15, 31, 65535, 1);
        load_data_set(1'b0);
        send_item(OP_RD_MEAN, MEAN_DEPTH-1, 0, 1'b0);
        send_item(OP_RD_LABEL, 1, 0, 1'b0);
        wait_drained();
    endtask

    initial begin
        cycle_count = 0;
        error_count = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        reg_ns = 256;
        reg_nc = 2;
        reg_nd = 3;
        reg_tol = 0;
        reg_lim = 100;
        for (int k = 0; k < MEAN_DEPTH; k++) begin
            mean_mem[k] = 0;
            mean_loaded[k] = 1'b0;
        end
        for (int k = 0; k < SMP_DEPTH; k++) smp_mem[k] = 0;
        for (int k = 0; k < DEF_MAX_SAMPLES; k++) label_mem[k] = 0;
        for (int k = 0; k < DEF_MAX_CLUSTERS; k++) cluster_size[k] = 0;
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_LD_SMP;
        in_ch.index  = '0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SAMPLE_COUNT;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 37;
        snk_idle_pct = 46;
        test_directed();
        test_random_sets(220);
        src_idle_pct = 46;
        snk_idle_pct = 37;
        test_random_sets(220);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_sets(220);
        test_largest();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
